// ===== design/bnc_pkg.sv =====
// ----------------------------------------------------------------------------
// bnc_pkg
// Types, constants and alphabet functions shared by the base-N codec.
// ----------------------------------------------------------------------------
package bnc_pkg;

    localparam logic [2:0] BASE_BIN  = 3'd0;
    localparam logic [2:0] BASE_HEXU = 3'd1;
    localparam logic [2:0] BASE_HEXL = 3'd2;
    localparam logic [2:0] BASE_B32  = 3'd3;
    localparam logic [2:0] BASE_B32H = 3'd4;
    localparam logic [2:0] BASE_B64  = 3'd5;
    localparam logic [2:0] BASE_B64U = 3'd6;

    localparam logic [2:0] CFG_DECODE  = 3'd0;
    localparam logic [2:0] CFG_BASE    = 3'd1;
    localparam logic [2:0] CFG_SKIP    = 3'd2;
    localparam logic [2:0] CFG_WRAP    = 3'd3;
    localparam logic [2:0] CFG_WRAP_NL = 3'd4;

    localparam logic [7:0] CH_PAD   = 8'h3D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       out_error;
    } out_item_t;

    typedef struct packed {
        logic        decode_mode;
        logic [2:0]  base_sel;
        logic        skip_garbage;
        logic [15:0] wrap_width;
        logic        wrap_newline;
    } cfg_t;

    typedef enum logic [1:0] {
        JOB_ENC,
        JOB_DEC,
        JOB_ERR
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [2:0]  base;
        logic [39:0] bits;
        logic [3:0]  cnt;
        logic [3:0]  total;
        logic        clr_col;
    } job_t;

    typedef struct packed {
        logic       hit;
        logic [5:0] val;
    } lookup_t;

    function automatic logic [2:0] char_bits(input logic [2:0] base);
        case (base)
            BASE_BIN:                         char_bits = 3'd1;
            BASE_HEXU, BASE_HEXL:             char_bits = 3'd4;
            BASE_B32, BASE_B32H:              char_bits = 3'd5;
            default:                          char_bits = 3'd6;
        endcase
    endfunction

    function automatic logic [2:0] group_bytes(input logic [2:0] base);
        case (base)
            BASE_BIN, BASE_HEXU, BASE_HEXL:   group_bytes = 3'd1;
            BASE_B32, BASE_B32H:              group_bytes = 3'd5;
            default:                          group_bytes = 3'd3;
        endcase
    endfunction

    function automatic logic [3:0] group_chars(input logic [2:0] base);
        case (base)
            BASE_BIN:                         group_chars = 4'd8;
            BASE_HEXU, BASE_HEXL:             group_chars = 4'd2;
            BASE_B32, BASE_B32H:              group_chars = 4'd8;
            default:                          group_chars = 4'd4;
        endcase
    endfunction

    function automatic logic is_padded(input logic [2:0] base);
        case (base)
            BASE_BIN, BASE_HEXU, BASE_HEXL:   is_padded = 1'b0;
            default:                          is_padded = 1'b1;
        endcase
    endfunction

    // data characters for nb bytes of a final group
    function automatic logic [3:0] data_chars(input logic [2:0] base, input logic [2:0] nb);
        logic [3:0] r;
        r = 4'd4;
        case (base)
            BASE_BIN:                         r = 4'd8;
            BASE_HEXU, BASE_HEXL:             r = 4'd2;
            BASE_B32, BASE_B32H:
            begin
                case (nb)
                    3'd1:    r = 4'd2;
                    3'd2:    r = 4'd4;
                    3'd3:    r = 4'd5;
                    3'd4:    r = 4'd7;
                    default: r = 4'd8;
                endcase
            end
            default:
            begin
                case (nb)
                    3'd1:    r = 4'd2;
                    3'd2:    r = 4'd3;
                    default: r = 4'd4;
                endcase
            end
        endcase
        data_chars = r;
    endfunction

    // bytes of a padded group, p = characters before the first pad
    function automatic logic [3:0] pad_bytes(input logic [2:0] base, input logic [3:0] p);
        logic [3:0] r;
        r = 4'd1;
        case (base)
            BASE_B32, BASE_B32H:
            begin
                case (p)
                    4'd4:         r = 4'd2;
                    4'd5, 4'd6:   r = 4'd3;
                    4'd7:         r = 4'd4;
                    default:      r = 4'd1;
                endcase
            end
            default:
            begin
                r = (p == 4'd3) ? 4'd2 : 4'd1;
            end
        endcase
        pad_bytes = r;
    endfunction

    function automatic logic [7:0] enc_char(input logic [2:0] base, input logic [5:0] v);
        logic [7:0] vv;
        logic [7:0] r;
        vv = {2'b00, v};
        r  = 8'h00;
        case (base)
            BASE_BIN:  r = 8'h30 + {7'd0, v[0]};
            BASE_HEXU, BASE_B32H: r = (vv < 8'd10) ? vv + 8'h30 : vv + 8'h37;
            BASE_HEXL: r = (vv < 8'd10) ? vv + 8'h30 : vv + 8'h57;
            BASE_B32:  r = (vv < 8'd26) ? vv + 8'h41 : vv + 8'h18;
            default:
            begin
                if (vv < 8'd26)
                    r = vv + 8'h41;
                else if (vv < 8'd52)
                    r = vv + 8'h47;
                else if (vv < 8'd62)
                    r = vv - 8'd4;
                else if (vv == 8'd62)
                    r = (base == BASE_B64U) ? 8'h2D : 8'h2B;
                else
                    r = (base == BASE_B64U) ? 8'h5F : 8'h2F;
            end
        endcase
        enc_char = r;
    endfunction

    function automatic lookup_t dec_char(input logic [2:0] base, input logic [7:0] ch);
        lookup_t r;
        logic    dig;
        logic    up;
        logic    lo;
        dig = (ch >= 8'h30) && (ch <= 8'h39);
        up  = (ch >= 8'h41) && (ch <= 8'h5A);
        lo  = (ch >= 8'h61) && (ch <= 8'h7A);
        r.hit = 1'b0;
        r.val = 6'd0;
        case (base)
            BASE_BIN:
            begin
                r.hit = (ch == 8'h30) || (ch == 8'h31);
                r.val = {5'd0, ch[0]};
            end
            BASE_HEXU:
            begin
                if (dig)
                begin
                    r.hit = 1'b1;
                    r.val = 6'(ch - 8'h30);
                end
                else if ((ch >= 8'h41) && (ch <= 8'h46))
                begin
                    r.hit = 1'b1;
                    r.val = 6'(ch - 8'h37);
                end
            end
            BASE_HEXL:
            begin
                if (dig)
                begin
                    r.hit = 1'b1;
                    r.val = 6'(ch - 8'h30);
                end
                else if ((ch >= 8'h61) && (ch <= 8'h66))
                begin
                    r.hit = 1'b1;
                    r.val = 6'(ch - 8'h57);
                end
            end
            BASE_B32:
            begin
                if (up)
                begin
                    r.hit = 1'b1;
                    r.val = 6'(ch - 8'h41);
                end
                else if ((ch >= 8'h32) && (ch <= 8'h37))
                begin
                    r.hit = 1'b1;
                    r.val = 6'(ch - 8'h18);
                end
            end
            BASE_B32H:
            begin
                if (dig)
                begin
                    r.hit = 1'b1;
                    r.val = 6'(ch - 8'h30);
                end
                else if ((ch >= 8'h41) && (ch <= 8'h56))
                begin
                    r.hit = 1'b1;
                    r.val = 6'(ch - 8'h37);
                end
            end
            default:
            begin
                if (up)
                begin
                    r.hit = 1'b1;
                    r.val = 6'(ch - 8'h41);
                end
                else if (lo)
                begin
                    r.hit = 1'b1;
                    r.val = 6'(ch - 8'h47);
                end
                else if (dig)
                begin
                    r.hit = 1'b1;
                    r.val = 6'(ch + 8'd4);
                end
                else if (ch == ((base == BASE_B64U) ? 8'h2D : 8'h2B))
                begin
                    r.hit = 1'b1;
                    r.val = 6'd62;
                end
                else if (ch == ((base == BASE_B64U) ? 8'h5F : 8'h2F))
                begin
                    r.hit = 1'b1;
                    r.val = 6'd63;
                end
            end
        endcase
        dec_char = r;
    endfunction

endpackage

// ===== design/bnc_front.sv =====
// ----------------------------------------------------------------------------
// bnc_front
// Accepts items, keeps the group state and turns each item into at most one job.
// ----------------------------------------------------------------------------
module bnc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  bnc_pkg::cfg_t     cfg,
    input  logic              cfg_clr,
    input  logic              in_valid,
    input  bnc_pkg::in_item_t in_data,
    input  logic              q_full,
    output logic              push,
    output bnc_pkg::job_t     push_job
);

    logic [39:0] gbits_reg;
    logic [39:0] gbits_next;
    logic [3:0]  gcnt_reg;
    logic [3:0]  gcnt_next;
    logic [3:0]  pad_reg;
    logic [3:0]  pad_next;
    logic        stopped_reg;
    logic        stopped_next;

    always_comb
    begin
        logic        acc;
        logic [2:0]  cb;
        logic [2:0]  gb;
        logic [3:0]  gc;
        logic [39:0] e_bits;
        logic [3:0]  e_cnt;
        logic [39:0] d_bits;
        logic [3:0]  d_cnt;
        logic [3:0]  npad;
        logic [5:0]  val;
        logic        take;
        logic        fail;
        logic        is_pad;
        logic        ws;
        logic        complete;
        bnc_pkg::lookup_t lk;

        acc = in_valid && !q_full;
        cb  = bnc_pkg::char_bits(cfg.base_sel);
        gb  = bnc_pkg::group_bytes(cfg.base_sel);
        gc  = bnc_pkg::group_chars(cfg.base_sel);

        gbits_next   = gbits_reg;
        gcnt_next    = gcnt_reg;
        pad_next     = pad_reg;
        stopped_next = stopped_reg;
        push         = 1'b0;
        push_job.kind    = bnc_pkg::JOB_ENC;
        push_job.base    = cfg.base_sel;
        push_job.bits    = 40'd0;
        push_job.cnt     = 4'd0;
        push_job.total   = gc;
        push_job.clr_col = in_data.in_last;

        e_bits = {gbits_reg[31:0], in_data.in_byte};
        e_cnt  = gcnt_reg + 4'd1;

        lk     = bnc_pkg::dec_char(cfg.base_sel, in_data.in_byte);
        is_pad = bnc_pkg::is_padded(cfg.base_sel) && (in_data.in_byte == bnc_pkg::CH_PAD);
        ws     = (in_data.in_byte == bnc_pkg::CH_SPACE) || (in_data.in_byte == bnc_pkg::CH_TAB)
                 || (in_data.in_byte == bnc_pkg::CH_LF) || (in_data.in_byte == bnc_pkg::CH_CR);
        fail   = 1'b0;
        take   = 1'b0;
        val    = lk.val;
        npad   = pad_reg;
        if (is_pad)
        begin
            if (gcnt_reg < 4'd2)
                fail = 1'b1;
            else
            begin
                if (pad_reg == 4'd0)
                    npad = gcnt_reg + 4'd1;
                val  = 6'd0;
                take = 1'b1;
            end
        end
        else if (lk.hit)
        begin
            if (pad_reg != 4'd0)
                fail = 1'b1;
            else
                take = 1'b1;
        end
        else if (!cfg.skip_garbage && !ws)
            fail = 1'b1;

        d_bits = gbits_reg;
        case (cb)
            3'd1:    d_bits = {gbits_reg[38:0], val[0]};
            3'd4:    d_bits = {gbits_reg[35:0], val[3:0]};
            3'd5:    d_bits = {gbits_reg[34:0], val[4:0]};
            default: d_bits = {gbits_reg[33:0], val};
        endcase
        if (!take)
            d_bits = gbits_reg;
        d_cnt    = take ? gcnt_reg + 4'd1 : gcnt_reg;
        complete = take && (d_cnt >= gc);

        if (cfg_clr)
        begin
            gbits_next = 40'd0;
            gcnt_next  = 4'd0;
            pad_next   = 4'd0;
        end
        else if (acc && !stopped_reg)
        begin
            if (!cfg.decode_mode)
            begin
                if ((e_cnt >= {1'b0, gb}) || in_data.in_last)
                begin
                    push          = 1'b1;
                    push_job.kind = bnc_pkg::JOB_ENC;
                    push_job.cnt  = bnc_pkg::data_chars(cfg.base_sel, e_cnt[2:0]);
                    case (e_cnt)
                        4'd1:    push_job.bits = {e_bits[7:0], 32'd0};
                        4'd2:    push_job.bits = {e_bits[15:0], 24'd0};
                        4'd3:    push_job.bits = {e_bits[23:0], 16'd0};
                        4'd4:    push_job.bits = {e_bits[31:0], 8'd0};
                        default: push_job.bits = e_bits;
                    endcase
                    gbits_next = 40'd0;
                    gcnt_next  = 4'd0;
                    pad_next   = 4'd0;
                end
                else
                begin
                    gbits_next = e_bits;
                    gcnt_next  = e_cnt;
                end
            end
            else
            begin
                if (!fail && in_data.in_last && !complete && (d_cnt != 4'd0))
                    fail = 1'b1;
                if (fail)
                begin
                    push          = 1'b1;
                    push_job.kind = bnc_pkg::JOB_ERR;
                    stopped_next  = 1'b1;
                    gbits_next    = 40'd0;
                    gcnt_next     = 4'd0;
                    pad_next      = 4'd0;
                end
                else if (complete)
                begin
                    push          = 1'b1;
                    push_job.kind = bnc_pkg::JOB_DEC;
                    push_job.cnt  = (npad != 4'd0)
                                    ? bnc_pkg::pad_bytes(cfg.base_sel, npad - 4'd1)
                                    : {1'b0, gb};
                    case (cfg.base_sel)
                        bnc_pkg::BASE_BIN, bnc_pkg::BASE_HEXU, bnc_pkg::BASE_HEXL:
                            push_job.bits = {d_bits[7:0], 32'd0};
                        bnc_pkg::BASE_B32, bnc_pkg::BASE_B32H:
                            push_job.bits = d_bits;
                        default:
                            push_job.bits = {d_bits[23:0], 16'd0};
                    endcase
                    gbits_next = 40'd0;
                    gcnt_next  = 4'd0;
                    pad_next   = 4'd0;
                end
                else
                begin
                    gbits_next = d_bits;
                    gcnt_next  = d_cnt;
                    pad_next   = npad;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gbits_reg   <= 40'd0;
            gcnt_reg    <= 4'd0;
            pad_reg     <= 4'd0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            gbits_reg   <= gbits_next;
            gcnt_reg    <= gcnt_next;
            pad_reg     <= pad_next;
            stopped_reg <= stopped_next;
        end
    end

    stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("stopped flag cleared without reset");

    no_job_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> !push)
        else $error("job issued after error");

endmodule

// ===== design/bnc_queue.sv =====
// ----------------------------------------------------------------------------
// bnc_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module bnc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bnc_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          head_valid,
    output bnc_pkg::job_t head_job
);

    localparam int PW = $clog2(bnc_pkg::QUEUE_DEPTH);

    bnc_pkg::job_t mem_reg [bnc_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_reg;
    logic [PW-1:0] wr_next;
    logic [PW-1:0] rd_reg;
    logic [PW-1:0] rd_next;
    logic [PW:0]   cnt_reg;
    logic [PW:0]   cnt_next;
    logic          do_pop;

    assign full       = (cnt_reg == (PW+1)'(bnc_pkg::QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = mem_reg[rd_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PW+1)'(push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

endmodule

// ===== design/bnc_back.sv =====
// ----------------------------------------------------------------------------
// bnc_back
// Runs jobs one result per cycle while the output is not stalled: characters, separators, bytes, errors.
// ----------------------------------------------------------------------------
module bnc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  bnc_pkg::cfg_t      cfg,
    input  logic               cfg_clr,
    input  logic               head_valid,
    input  bnc_pkg::job_t      head_job,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output bnc_pkg::out_item_t out_data
);

    logic               cur_valid_reg;
    logic               cur_valid_next;
    bnc_pkg::job_t      job_reg;
    bnc_pkg::job_t      job_next;
    logic [39:0]        sh_reg;
    logic [39:0]        sh_next;
    logic [3:0]         idx_reg;
    logic [3:0]         idx_next;
    logic [15:0]        col_reg;
    logic [15:0]        col_next;
    logic               ov_reg;
    logic               ov_next;
    bnc_pkg::out_item_t od_reg;
    bnc_pkg::out_item_t od_next;

    always_comb
    begin
        logic       adv;
        logic       emit;
        logic       sep;
        logic       done;
        logic       ld;
        logic [2:0] cb;
        logic [5:0] v;
        bnc_pkg::out_item_t r;

        adv  = !ov_reg || !out_stall;
        emit = cur_valid_reg && adv;
        cb   = bnc_pkg::char_bits(job_reg.base);
        sep  = (job_reg.kind == bnc_pkg::JOB_ENC) && (cfg.wrap_width != 16'd0)
               && (col_reg >= cfg.wrap_width);
        case (cb)
            3'd1:    v = {5'd0, sh_reg[39]};
            3'd4:    v = {2'd0, sh_reg[39:36]};
            3'd5:    v = {1'd0, sh_reg[39:35]};
            default: v = sh_reg[39:34];
        endcase

        r.out_error = 1'b0;
        r.out_last  = 1'b0;
        r.out_byte  = 8'd0;
        unique case (job_reg.kind)
            bnc_pkg::JOB_ERR:
            begin
                r.out_error = 1'b1;
                r.out_last  = 1'b1;
            end
            bnc_pkg::JOB_DEC:
            begin
                r.out_byte = sh_reg[39:32];
                r.out_last = (idx_reg == job_reg.cnt - 4'd1);
            end
            bnc_pkg::JOB_ENC:
            begin
                if (sep)
                    r.out_byte = cfg.wrap_newline ? bnc_pkg::CH_LF : bnc_pkg::CH_SPACE;
                else
                begin
                    r.out_byte = (idx_reg < job_reg.cnt) ? bnc_pkg::enc_char(job_reg.base, v)
                                                         : bnc_pkg::CH_PAD;
                    r.out_last = (idx_reg == job_reg.total - 4'd1);
                end
            end
            default:
            begin
                r.out_error = 1'b1;
                r.out_last  = 1'b1;
            end
        endcase

        done = emit && r.out_last;
        ld   = !cur_valid_reg || done;
        pop  = ld;

        ov_next  = adv ? emit : ov_reg;
        od_next  = emit ? r : od_reg;
        sh_next  = sh_reg;
        idx_next = idx_reg;
        col_next = col_reg;
        job_next = job_reg;
        cur_valid_next = cur_valid_reg;

        if (emit)
        begin
            if (job_reg.kind == bnc_pkg::JOB_DEC)
            begin
                sh_next  = {sh_reg[31:0], 8'd0};
                idx_next = idx_reg + 4'd1;
            end
            else if (job_reg.kind == bnc_pkg::JOB_ENC)
            begin
                if (sep)
                    col_next = 16'd0;
                else
                begin
                    if (col_reg != 16'hFFFF)
                        col_next = col_reg + 16'd1;
                    idx_next = idx_reg + 4'd1;
                    case (cb)
                        3'd1:    sh_next = {sh_reg[38:0], 1'd0};
                        3'd4:    sh_next = {sh_reg[35:0], 4'd0};
                        3'd5:    sh_next = {sh_reg[34:0], 5'd0};
                        default: sh_next = {sh_reg[33:0], 6'd0};
                    endcase
                end
            end
            if (done && job_reg.clr_col)
                col_next = 16'd0;
        end
        if (cfg_clr)
            col_next = 16'd0;

        if (ld)
        begin
            cur_valid_next = head_valid;
            job_next       = head_job;
            sh_next        = head_job.bits;
            idx_next       = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            col_reg       <= 16'd0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            col_reg       <= col_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        sh_reg  <= sh_next;
        idx_reg <= idx_next;
        od_reg  <= od_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    error_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && od_reg.out_error) |-> (od_reg.out_last && (od_reg.out_byte == 8'd0)))
        else $error("error result malformed");

    separator_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && od_reg.out_last && !od_reg.out_error && !cfg.decode_mode)
        |-> (od_reg.out_byte != bnc_pkg::CH_SPACE) && (od_reg.out_byte != bnc_pkg::CH_LF))
        else $error("separator closed a transfer group");

endmodule

// ===== design/base_n_codec.sv =====
// ----------------------------------------------------------------------------
// base_n_codec
// Streaming base2/16/32/64 encoder and decoder with line wrapping.
// ----------------------------------------------------------------------------
// An input transfer is taken whenever the job queue (four entries) has room;
// the front updates the group state and queues at most one job per item.
// The back drains jobs through an output register at one result per cycle
// while out_stall is low. An item causes up to 16 results (base2 encode:
// 8 characters plus up to 8 separators). From an idle back the first result
// of an item passes through the queue, the back's job register and the
// output register. The single result port sets the sustained rate.
module base_n_codec (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  bnc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output bnc_pkg::out_item_t out_data
);

    bnc_pkg::cfg_t cfg_reg;
    bnc_pkg::cfg_t cfg_next;
    logic          cfg_clr;
    logic          q_full;
    logic          push;
    bnc_pkg::job_t push_job;
    logic          pop;
    logic          head_valid;
    bnc_pkg::job_t head_job;

    assign cfg_clr = cfg_we && ((cfg_index == bnc_pkg::CFG_DECODE)
                                || (cfg_index == bnc_pkg::CFG_BASE));
    assign in_stall = q_full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bnc_pkg::CFG_DECODE:  cfg_next.decode_mode  = cfg_data[0];
                bnc_pkg::CFG_BASE:    cfg_next.base_sel     = cfg_data[2:0];
                bnc_pkg::CFG_SKIP:    cfg_next.skip_garbage = cfg_data[0];
                bnc_pkg::CFG_WRAP:    cfg_next.wrap_width   = cfg_data;
                bnc_pkg::CFG_WRAP_NL: cfg_next.wrap_newline = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decode_mode  <= 1'b0;
            cfg_reg.base_sel     <= bnc_pkg::BASE_B64;
            cfg_reg.skip_garbage <= 1'b0;
            cfg_reg.wrap_width   <= 16'd0;
            cfg_reg.wrap_newline <= 1'b0;
        end
        else
            cfg_reg <= cfg_next;
    end

    bnc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cfg_clr  (cfg_clr),
        .in_valid (in_valid),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    bnc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    bnc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cfg_clr    (cfg_clr),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
